// ===== src/slsq_pkg.sv =====
`default_nettype none

package slsq_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_DUTY_MID          = 3'd0;
    localparam logic [2:0] CFG_DUTY_MIN          = 3'd1;
    localparam logic [2:0] CFG_DUTY_MAX          = 3'd2;
    localparam logic [2:0] CFG_DUTY_STEP         = 3'd3;
    localparam logic [2:0] CFG_CURRENT_THRESHOLD = 3'd4;
    localparam logic [2:0] CFG_QUIET_LIMIT       = 3'd5;
    localparam logic [2:0] CFG_STALL_PERIODS     = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_DUTY_MID          = 16'd1500;
    localparam logic [15:0] RST_DUTY_MIN          = 16'd300;
    localparam logic [15:0] RST_DUTY_MAX          = 16'd3000;
    localparam logic [15:0] RST_DUTY_STEP         = 16'd15;
    localparam logic [7:0]  RST_CURRENT_THRESHOLD = 8'd250;
    localparam logic [7:0]  RST_QUIET_LIMIT       = 8'd9;
    localparam logic [7:0]  RST_STALL_PERIODS     = 8'd15;

    // Phase code reported once the search is over
    localparam logic [2:0] PHASE_STOPPED_CODE = 3'd6;

    // Event kinds on the input stream
    localparam logic ACT_ADC_SAMPLE = 1'b0;
    localparam logic ACT_PERIOD_END = 1'b1;

    typedef struct packed {
        logic [15:0] duty_mid;
        logic [15:0] duty_min;
        logic [15:0] duty_max;
        logic [15:0] duty_step;
        logic [7:0]  current_threshold;
        logic [7:0]  quiet_limit;
        logic [7:0]  stall_periods;
    } t_slsq_cfg;

    typedef struct packed {
        logic        output_enabled;
        logic [2:0]  phase_code;
        logic        below_threshold;
        logic [15:0] duty_compare;
    } t_slsq_result;

endpackage

`default_nettype wire

// ===== src/slsq_core.sv =====
`default_nettype none

module slsq_core
    import slsq_pkg::*;
#(
    parameter int DUTY_WIDTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire logic         i_action,
    input  wire logic [7:0]   i_sample,
    input  wire t_slsq_cfg    i_cfg,
    output t_slsq_result      o_next,
    output logic              o_stopped
);

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_WAIT     = 3'd1,
        PH_SHRINK   = 3'd2,
        PH_PAST     = 3'd3,
        PH_GROW     = 3'd4,
        PH_STOPPING = 3'd5,
        PH_STOPPED  = PHASE_STOPPED_CODE
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [DUTY_WIDTH-1:0]   r_width, n_width;
    logic [7:0]              r_loaded, n_loaded;
    logic [7:0]              r_count, n_count;
    logic                    r_below, n_below;

    logic [DUTY_WIDTH-1:0]   w_mid, w_min, w_max, w_stepw;
    logic [DUTY_WIDTH:0]     w_dec, w_inc;
    logic [DUTY_WIDTH-1:0]   w_dn_width, w_up_width;
    logic                    w_dn_stop, w_up_stop;
    logic [7:0]              w_loaded_inc;

    assign w_mid   = DUTY_WIDTH'(i_cfg.duty_mid);
    assign w_min   = DUTY_WIDTH'(i_cfg.duty_min);
    assign w_max   = DUTY_WIDTH'(i_cfg.duty_max);
    assign w_stepw = DUTY_WIDTH'(i_cfg.duty_step);

    // Saturating width moves: a borrow pins to zero, a carry to all ones
    assign w_dec = {1'b0, r_width} - {1'b0, w_stepw};
    assign w_inc = {1'b0, r_width} + {1'b0, w_stepw};
    assign w_dn_width = w_dec[DUTY_WIDTH] ? '0 : w_dec[DUTY_WIDTH-1:0];
    assign w_up_width = w_inc[DUTY_WIDTH] ? '1 : w_inc[DUTY_WIDTH-1:0];
    assign w_dn_stop  = w_dec[DUTY_WIDTH] || (w_dec[DUTY_WIDTH-1:0] < w_min);
    assign w_up_stop  = w_inc[DUTY_WIDTH] || (w_inc[DUTY_WIDTH-1:0] > w_max);

    assign w_loaded_inc = (r_loaded == 8'hFF) ? r_loaded : r_loaded + 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_width  = r_width;
        n_loaded = r_loaded;
        n_count  = r_count;
        n_below  = r_below;
        if (i_step && r_phase != PH_STOPPED) begin
            if (i_action == ACT_ADC_SAMPLE) begin
                n_below = (i_sample < i_cfg.current_threshold);
                if (n_below && r_count != 8'hFF) begin
                    n_count = r_count + 8'd1;
                end
            end else begin
                n_count = '0;
                unique case (r_phase)
                    PH_START: begin
                        n_width = w_mid;
                        n_phase = PH_WAIT;
                    end
                    PH_WAIT: begin
                        if (r_count != 8'd0) n_phase = PH_SHRINK;
                    end
                    PH_SHRINK: begin
                        if (r_count < i_cfg.quiet_limit) begin
                            n_loaded = '0;
                            n_width  = w_dn_width;
                            if (w_dn_stop) n_phase = PH_STOPPING;
                        end else begin
                            n_loaded = w_loaded_inc;
                            if (w_loaded_inc > i_cfg.stall_periods) n_phase = PH_PAST;
                        end
                    end
                    PH_PAST: begin
                        if (r_count > i_cfg.quiet_limit) begin
                            n_width = w_up_width;
                            if (w_up_stop) n_phase = PH_STOPPING;
                        end else begin
                            n_phase = PH_GROW;
                        end
                    end
                    PH_GROW: begin
                        if (r_count < i_cfg.quiet_limit) begin
                            n_loaded = '0;
                            n_width  = w_up_width;
                            if (w_up_stop) n_phase = PH_STOPPING;
                        end else begin
                            n_loaded = w_loaded_inc;
                            if (w_loaded_inc > i_cfg.stall_periods) n_phase = PH_STOPPING;
                        end
                    end
                    // stopping, and the unused code
                    default: n_phase = PH_STOPPED;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_width  <= '0;
            r_loaded <= '0;
            r_count  <= '0;
            r_below  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_loaded <= n_loaded;
            r_count  <= n_count;
            r_below  <= n_below;
        end
    end

    assign o_next.duty_compare    = 16'(n_width);
    assign o_next.below_threshold = n_below;
    assign o_next.phase_code      = n_phase;
    assign o_next.output_enabled  = (n_phase != PH_STOPPED);
    assign o_stopped              = (r_phase == PH_STOPPED);

endmodule

`default_nettype wire

// ===== src/servo_limit_search_sequencer.sv =====
// A result is registered: it appears on the master side in the cycle after its request is taken.
// Throughput: one request per cycle; the slave side stalls only while a result waits.
// Every request gives exactly one result; the phase machine updates in that same cycle.
// Reset (i_rst_n low, synchronous): phase to start, width and counters to zero,
// registers to their defaults, no result pending.
`default_nettype none

module servo_limit_search_sequencer
    import slsq_pkg::*;
#(
    parameter int DUTY_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] adc_sample
    input  wire logic        i_s_axis_tuser,   // [0] action
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] duty_compare, [16] below_threshold, [19:17] phase_code,
    // [20] output_enabled, [23:21] zero
    output logic [23:0]      o_m_axis_tdata,
    // register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_slsq_cfg    r_cfg;
    t_slsq_result r_out;
    logic         r_out_valid;
    t_slsq_result w_next;
    logic         w_accept;
    logic         w_stopped;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_mid          <= RST_DUTY_MID;
            r_cfg.duty_min          <= RST_DUTY_MIN;
            r_cfg.duty_max          <= RST_DUTY_MAX;
            r_cfg.duty_step         <= RST_DUTY_STEP;
            r_cfg.current_threshold <= RST_CURRENT_THRESHOLD;
            r_cfg.quiet_limit       <= RST_QUIET_LIMIT;
            r_cfg.stall_periods     <= RST_STALL_PERIODS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DUTY_MID:          r_cfg.duty_mid          <= i_cfg_data;
                CFG_DUTY_MIN:          r_cfg.duty_min          <= i_cfg_data;
                CFG_DUTY_MAX:          r_cfg.duty_max          <= i_cfg_data;
                CFG_DUTY_STEP:         r_cfg.duty_step         <= i_cfg_data;
                CFG_CURRENT_THRESHOLD: r_cfg.current_threshold <= i_cfg_data[7:0];
                CFG_QUIET_LIMIT:       r_cfg.quiet_limit       <= i_cfg_data[7:0];
                CFG_STALL_PERIODS:     r_cfg.stall_periods     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    slsq_core #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_accept),
        .i_action  (i_s_axis_tuser),
        .i_sample  (i_s_axis_tdata),
        .i_cfg     (r_cfg),
        .o_next    (w_next),
        .o_stopped (w_stopped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out};

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_m_axis_tvalid)
        else $error("accepted request gave no result");

    a_stop_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stopped |=> w_stopped)
        else $error("search left the stopped phase");

    a_enable_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[20] == (o_m_axis_tdata[19:17] != PHASE_STOPPED_CODE)))
        else $error("output enable disagrees with phase");

endmodule

`default_nettype wire

// ===== tb/tb_servo_limit_search_sequencer.sv =====
module tb_servo_limit_search_sequencer;
    import slsq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime CLK_PERIOD     = 12.0;
    localparam int      TIMEOUT_CYCLES = 500_000;
    localparam int      LONG_HOLD      = 200;
    localparam logic [2:0] CFG_NO_SUCH_REG = 3'd7;

    typedef enum logic [2:0] {
        SRCH_START         = 3'd0,
        SRCH_WAIT_MOTION   = 3'd1,
        SRCH_SHRINK        = 3'd2,
        SRCH_GROW_PAST     = 3'd3,
        SRCH_GROW_TO_STALL = 3'd4,
        SRCH_STOPPING      = 3'd5,
        SRCH_STOPPED       = PHASE_STOPPED_CODE
    } search_phase_e;

    // how the single search of this run is brought to its end
    typedef enum int {
        END_BORROW,
        END_BELOW_MIN,
        END_CARRY,
        END_ABOVE_MAX,
        END_STALL
    } stop_route_e;

    typedef struct packed {
        logic       action;
        logic [7:0] sample;
    } sensor_event_t;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'd0;   // [7:0] adc_sample
    logic        i_s_axis_tuser  = 1'b0;   // [0] action
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [15:0] duty_compare, [16] below_threshold, [19:17] phase_code,
    // [20] output_enabled, [23:21] zero
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index     = 3'd0;
    logic [15:0] i_cfg_data      = 16'd0;

    servo_limit_search_sequencer #(
        .DUTY_WIDTH (16)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // predicted state of the sequencer
    t_slsq_cfg     model_cfg;
    search_phase_e model_phase;
    logic [15:0]   model_width;
    logic [7:0]    model_loaded;
    logic [7:0]    model_low_count;
    logic          model_below;

    sensor_event_t event_queue[$];
    t_slsq_result  expected_readings[$];

    int   mismatch_count = 0;
    int   send_gap       = 0;
    int   recv_hold      = 0;
    logic req_fired      = 1'b0;
    logic idle_enabled   = 1'b1;
    logic pressure_armed = 1'b0;
    logic pressure_done  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic void step_width_up();
        logic [16:0] sum;
        sum = {1'b0, model_width} + {1'b0, model_cfg.duty_step};
        if (sum[16]) begin
            model_width = 16'hFFFF;
            model_phase = SRCH_STOPPING;
        end else begin
            model_width = sum[15:0];
            if (model_width > model_cfg.duty_max)
                model_phase = SRCH_STOPPING;
        end
    endfunction

    function automatic void count_loaded_period(input search_phase_e stall_phase);
        if (model_loaded != 8'hFF)
            model_loaded++;
        if (model_loaded > model_cfg.stall_periods)
            model_phase = stall_phase;
    endfunction

    function automatic t_slsq_result advance_search(input logic action, input logic [7:0] sample);
        t_slsq_result res;
        logic [7:0]   cnt;
        if (model_phase != SRCH_STOPPED) begin
            if (action == ACT_ADC_SAMPLE) begin
                if (sample < model_cfg.current_threshold) begin
                    if (model_low_count != 8'hFF)
                        model_low_count++;
                    model_below = 1'b1;
                end else begin
                    model_below = 1'b0;
                end
            end else begin
                cnt = model_low_count;
                case (model_phase)
                    SRCH_START: begin
                        model_width = model_cfg.duty_mid;
                        model_phase = SRCH_WAIT_MOTION;
                    end
                    SRCH_WAIT_MOTION: begin
                        if (cnt != 8'd0)
                            model_phase = SRCH_SHRINK;
                    end
                    SRCH_SHRINK: begin
                        if (cnt < model_cfg.quiet_limit) begin
                            model_loaded = 8'd0;
                            if (model_cfg.duty_step > model_width) begin
                                model_width = 16'd0;
                                model_phase = SRCH_STOPPING;
                            end else begin
                                model_width = model_width - model_cfg.duty_step;
                                if (model_width < model_cfg.duty_min)
                                    model_phase = SRCH_STOPPING;
                            end
                        end else begin
                            count_loaded_period(SRCH_GROW_PAST);
                        end
                    end
                    SRCH_GROW_PAST: begin
                        if (cnt > model_cfg.quiet_limit)
                            step_width_up();
                        else
                            model_phase = SRCH_GROW_TO_STALL;
                    end
                    SRCH_GROW_TO_STALL: begin
                        if (cnt < model_cfg.quiet_limit) begin
                            model_loaded = 8'd0;
                            step_width_up();
                        end else begin
                            count_loaded_period(SRCH_STOPPING);
                        end
                    end
                    // stopping, and the unused code 7
                    default: model_phase = SRCH_STOPPED;
                endcase
                model_low_count = 8'd0;
            end
        end
        res.duty_compare    = model_width;
        res.below_threshold = model_below;
        res.phase_code      = model_phase;
        res.output_enabled  = (model_phase != SRCH_STOPPED);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISCOMPARE @ %0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic push_event(input logic action, input logic [7:0] sample);
        sensor_event_t ev;
        ev.action = action;
        ev.sample = sample;
        event_queue.push_back(ev);
    endtask

    task automatic push_sample(input logic [7:0] sample);
        push_event(ACT_ADC_SAMPLE, sample);
    endtask

    // one PWM period: samples below and at/above threshold in random order, then the end
    task automatic push_period(input int n_below, input int n_above);
        int below_left;
        int above_left;
        logic [7:0] thr;
        below_left = n_below;
        above_left = n_above;
        thr = model_cfg.current_threshold;
        while (below_left + above_left > 0) begin
            if (below_left > 0 && thr != 8'd0 && (above_left == 0 || $urandom_range(0, 1) == 1)) begin
                push_sample(8'($urandom_range(0, thr - 1)));
                below_left--;
            end else begin
                push_sample(8'($urandom_range(thr, 255)));
                if (above_left > 0)
                    above_left--;
                else
                    below_left--;
            end
        end
        push_event(ACT_PERIOD_END, 8'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        logic [15:0] bus;
        bus = data;
        // byte registers ignore the upper byte
        if (idx >= CFG_CURRENT_THRESHOLD)
            bus[15:8] = 8'($urandom);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= bus;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DUTY_MID:          model_cfg.duty_mid          = bus;
            CFG_DUTY_MIN:          model_cfg.duty_min          = bus;
            CFG_DUTY_MAX:          model_cfg.duty_max          = bus;
            CFG_DUTY_STEP:         model_cfg.duty_step         = bus;
            CFG_CURRENT_THRESHOLD: model_cfg.current_threshold = bus[7:0];
            CFG_QUIET_LIMIT:       model_cfg.quiet_limit       = bus[7:0];
            CFG_STALL_PERIODS:     model_cfg.stall_periods     = bus[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (event_queue.size() != 0 || expected_readings.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (req_fired)
            void'(event_queue.pop_front());
        if (!i_s_axis_tvalid || req_fired) begin
            if (send_gap > 0) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (event_queue.size() != 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= event_queue[0].action;
                i_s_axis_tdata  <= event_queue[0].sample;
                if (idle_enabled && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 16);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold--;
            i_m_axis_tready <= 1'b0;
        end else if (pressure_armed && !pressure_done) begin
            pressure_done = 1'b1;
            recv_hold = LONG_HOLD - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            recv_hold = $urandom_range(0, 15);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // monitor: check results first, then predict the request taken at this edge
    always @(posedge i_clk) begin
        t_slsq_result got;
        t_slsq_result want;
        if (!i_rst_n) begin
            req_fired <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_readings.pop_front();
                    got  = o_m_axis_tdata[20:0];
                    if (got.duty_compare !== want.duty_compare)
                        report_mismatch($sformatf("duty_compare got %0d want %0d",
                                                  got.duty_compare, want.duty_compare));
                    if (got.below_threshold !== want.below_threshold)
                        report_mismatch($sformatf("below_threshold got %0b want %0b",
                                                  got.below_threshold, want.below_threshold));
                    if (got.phase_code !== want.phase_code)
                        report_mismatch($sformatf("phase_code got %0d want %0d",
                                                  got.phase_code, want.phase_code));
                    if (got.output_enabled !== want.output_enabled)
                        report_mismatch($sformatf("output_enabled got %0b want %0b",
                                                  got.output_enabled, want.output_enabled));
                    if (o_m_axis_tdata[23:21] !== 3'b000)
                        report_mismatch($sformatf("pad bits got %b", o_m_axis_tdata[23:21]));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_readings.push_back(advance_search(i_s_axis_tuser, i_s_axis_tdata));
            req_fired <= i_s_axis_tvalid && o_s_axis_tready;
        end
    end

    initial begin
        int          quiet;
        int          step_cap;
        logic [7:0]  thr;
        stop_route_e stop_route;

        model_cfg = '{duty_mid: RST_DUTY_MID, duty_min: RST_DUTY_MIN, duty_max: RST_DUTY_MAX,
                      duty_step: RST_DUTY_STEP, current_threshold: RST_CURRENT_THRESHOLD,
                      quiet_limit: RST_QUIET_LIMIT, stall_periods: RST_STALL_PERIODS};
        model_phase     = SRCH_START;
        model_width     = 16'd0;
        model_loaded    = 8'd0;
        model_low_count = 8'd0;
        model_below     = 1'b0;
        stop_route      = stop_route_e'($urandom_range(0, 4));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_NO_SUCH_REG, 16'($urandom));

        // directed part on reset defaults
        push_sample(8'd0);
        push_sample(8'd255);
        push_sample(8'd249);                 // just below threshold
        push_sample(8'd250);                 // at threshold: not counted
        push_event(ACT_PERIOD_END, 8'hFF);   // start -> wait for motion
        push_event(ACT_PERIOD_END, 8'h00);   // no motion seen, stay
        push_sample(8'd100);
        push_event(ACT_PERIOD_END, 8'h5A);   // motion -> shrink
        push_period(3, 2);                   // quiet, width steps down
        push_period(9, 1);                   // count equal to limit is loaded
        wait_drained();

        // shrink with random periods, never stalling
        thr      = 8'($urandom_range(60, 200));
        quiet    = $urandom_range(1, 8);
        step_cap = model_width / 64;
        if (step_cap > 40)
            step_cap = 40;
        write_reg(CFG_DUTY_MID, 16'($urandom));
        write_reg(CFG_DUTY_MIN, 16'd0);
        write_reg(CFG_DUTY_MAX, 16'hFFFF);
        write_reg(CFG_DUTY_STEP, 16'($urandom_range(0, step_cap)));
        write_reg(CFG_CURRENT_THRESHOLD, 16'(thr));
        write_reg(CFG_QUIET_LIMIT, 16'(quiet));
        write_reg(CFG_STALL_PERIODS, 16'd255);
        repeat (12) begin
            if ($urandom_range(0, 3) == 0)
                push_event(1'($urandom), 8'($urandom));
            push_period($urandom_range(0, 2 * quiet), $urandom_range(0, 3));
        end
        wait_drained();

        // low-sample count must pin at 255; receiver holds off meanwhile
        write_reg(CFG_CURRENT_THRESHOLD, 16'd255);
        write_reg(CFG_QUIET_LIMIT, 16'd255);
        pressure_armed = 1'b1;
        repeat (257) push_sample(8'($urandom_range(0, 254)));
        push_event(ACT_PERIOD_END, 8'($urandom));
        wait_drained();

        if (stop_route == END_BORROW || stop_route == END_BELOW_MIN) begin
            write_reg(CFG_QUIET_LIMIT, 16'd1);
            if (stop_route == END_BORROW) begin
                write_reg(CFG_DUTY_STEP, 16'hFFFF);
            end else begin
                write_reg(CFG_DUTY_STEP, 16'd1);
                write_reg(CFG_DUTY_MIN, 16'hFFFF);
            end
            push_period(0, $urandom_range(0, 2));
        end else begin
            // every period loaded: loaded count pins at 255
            write_reg(CFG_QUIET_LIMIT, 16'd0);
            write_reg(CFG_CURRENT_THRESHOLD, 16'd0);
            repeat (258) push_period(0, ($urandom_range(0, 7) == 0) ? 1 : 0);
            wait_drained();
            write_reg(CFG_STALL_PERIODS, 16'd254);
            push_period(0, 0);               // pinned count now exceeds limit
            wait_drained();

            // grow past the stall, then grow toward the next one
            thr   = 8'($urandom_range(100, 200));
            quiet = $urandom_range(2, 6);
            write_reg(CFG_CURRENT_THRESHOLD, 16'(thr));
            write_reg(CFG_QUIET_LIMIT, 16'(quiet));
            write_reg(CFG_DUTY_STEP, 16'($urandom_range(0, 30)));
            write_reg(CFG_STALL_PERIODS, 16'd255);
            repeat ($urandom_range(3, 8))
                push_period(quiet + 1 + $urandom_range(0, 3), $urandom_range(0, 2));
            push_period($urandom_range(0, quiet), $urandom_range(0, 3));
            repeat (15) begin
                if ($urandom_range(0, 4) == 0)
                    push_sample(8'($urandom));
                push_period($urandom_range(0, 2 * quiet), $urandom_range(0, 3));
            end
            wait_drained();

            case (stop_route)
                END_CARRY: begin
                    write_reg(CFG_QUIET_LIMIT, 16'd1);
                    write_reg(CFG_DUTY_MAX, 16'hFFFF);
                    write_reg(CFG_DUTY_STEP, 16'hFFFF);
                    push_period(0, 1);
                end
                END_ABOVE_MAX: begin
                    write_reg(CFG_QUIET_LIMIT, 16'd1);
                    write_reg(CFG_DUTY_STEP, 16'($urandom_range(1, 20)));
                    write_reg(CFG_DUTY_MAX, 16'd0);
                    push_period(0, 1);
                end
                default: begin
                    write_reg(CFG_QUIET_LIMIT, 16'd0);
                    write_reg(CFG_STALL_PERIODS, 16'd0);
                    push_period($urandom_range(0, 2), 0);
                end
            endcase
        end
        wait_drained();

        // stopping -> stopped, then everything is ignored; no idling from here
        idle_enabled = 1'b0;
        write_reg(CFG_DUTY_MID, 16'd0);
        write_reg(CFG_DUTY_MID, 16'hFFFF);
        push_event(ACT_PERIOD_END, 8'($urandom));
        repeat (12) push_event(1'($urandom), 8'($urandom));
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Mismatches found");
        $finish;
    end

endmodule
